FILE: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the slab buffer cache allocator
// Sizes of the slab pool, field widths, operation and status codes and the
// payload structs of the request and response channels.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int NUM_SLABS        = 16;
	localparam int FRAMES_PER_SLAB  = 64;
	localparam int FRAME_BYTES_LOG2 = 12;

	localparam int MODE_W  = 2;
	localparam int REQ_W   = 8;
	localparam int ADDR_W  = 22;
	localparam int GRANT_W = 7;
	localparam int STAT_W  = 2;

	// frame number width and store geometry (two spare slabs beyond the pool)
	localparam int FNUM_W     = ADDR_W - FRAME_BYTES_LOG2;
	localparam int NUM_ROWS   = NUM_SLABS + 2;
	localparam int STORE_SIZE = NUM_ROWS * FRAMES_PER_SLAB;
	localparam int STORE_AW   = $clog2(STORE_SIZE);
	localparam int SLAB_W     = $clog2(NUM_ROWS);
	localparam int SLOT_W     = (FRAMES_PER_SLAB > 1) ? $clog2(FRAMES_PER_SLAB) : 1;
	localparam int CNT_W      = $clog2(FRAMES_PER_SLAB + 1);
	localparam int STK_W      = $clog2(NUM_SLABS + 1);
	localparam int STK_IDX_W  = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_CHECK   = 2'd0,
		MODE_CONSUME = 2'd1,
		MODE_PRODUCE = 2'd2
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [REQ_W-1:0]  request_count;
		logic [ADDR_W-1:0] frame_address;
	} req_item_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_count;
		logic [ADDR_W-1:0]  out_address;
		logic [STAT_W-1:0]  status;
	} rsp_item_t;

	// controller commands to the datapath
	typedef struct packed {
		logic accept;
		logic exec;
	} dp_cmd_t;

endpackage

FILE: rtl/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_if: request and response channel interfaces
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface sbc_req_if;
	logic               valid;
	logic               ready;
	sbc_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sbc_rsp_if;
	logic               valid;
	logic               ready;
	sbc_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl: sequencing controller
// Accepts a request, runs it once the response register is free, and owns
// the response valid flag.
// ----------------------------------------------------------------------------
module sbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sbc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;

	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd.accept = req_ready && req_valid;
		cmd.exec   = (state_q == ST_EXEC) && (!out_valid_q || rsp_ready);
		state_n    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.exec) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

FILE: rtl/sbc_dp.sv
// ----------------------------------------------------------------------------
// sbc_dp: allocator datapath
// Slab stack, take and give slab registers, frame store memory with per-slab
// written flags, and the response register.
// ----------------------------------------------------------------------------
module sbc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sbc_pkg::dp_cmd_t    cmd,
	input  sbc_pkg::req_item_t  req_data,
	output sbc_pkg::rsp_item_t  rsp_data
);

	localparam int NS  = sbc_pkg::NUM_SLABS;
	localparam int FPS = sbc_pkg::FRAMES_PER_SLAB;
	localparam int FB  = sbc_pkg::FRAME_BYTES_LOG2;

	sbc_pkg::req_item_t op_q;
	sbc_pkg::rsp_item_t rsp_q;

	logic [sbc_pkg::SLAB_W-1:0]   stack_q [NS];
	logic [sbc_pkg::STK_W-1:0]    stk_cnt_q;
	logic [sbc_pkg::SLAB_W-1:0]   take_slab_q;
	logic [sbc_pkg::CNT_W-1:0]    take_cnt_q;
	logic [sbc_pkg::SLAB_W-1:0]   give_slab_q;
	logic [sbc_pkg::CNT_W-1:0]    give_cnt_q;
	logic [sbc_pkg::NUM_ROWS-1:0] written_q;

	logic [sbc_pkg::FNUM_W-1:0]   store_mem [sbc_pkg::STORE_SIZE];
	logic [sbc_pkg::FNUM_W-1:0]   rd_data_q;

	logic [sbc_pkg::STORE_AW-1:0] take_addr;
	logic [sbc_pkg::SLOT_W-1:0]   take_slot;
	logic [sbc_pkg::FNUM_W-1:0]   fnum_in;
	logic [sbc_pkg::FNUM_W-1:0]   fnum_out;
	logic [sbc_pkg::STK_IDX_W-1:0] stk_idx;

	logic                         stk_we;
	logic [sbc_pkg::SLAB_W-1:0]   stk_wdata;
	logic [sbc_pkg::STK_W-1:0]    stk_cnt_n;
	logic [sbc_pkg::SLAB_W-1:0]   take_slab_n;
	logic [sbc_pkg::CNT_W-1:0]    take_cnt_n;
	logic [sbc_pkg::SLAB_W-1:0]   give_slab_n;
	logic [sbc_pkg::CNT_W-1:0]    give_cnt_n;
	logic                         mem_we;
	logic [sbc_pkg::SLAB_W-1:0]   wr_slab;
	logic [sbc_pkg::SLOT_W-1:0]   wr_slot;
	logic [sbc_pkg::STORE_AW-1:0] wr_addr;
	sbc_pkg::rsp_item_t           rsp_n;

	// slot of the next frame to hand out; wraps harmlessly when the slab is empty
	assign take_slot = sbc_pkg::SLOT_W'(take_cnt_q - sbc_pkg::CNT_W'(1));
	assign take_addr = sbc_pkg::STORE_AW'(take_slab_q) * sbc_pkg::STORE_AW'(FPS)
		+ sbc_pkg::STORE_AW'(take_slot);
	assign wr_addr   = sbc_pkg::STORE_AW'(wr_slab) * sbc_pkg::STORE_AW'(FPS)
		+ sbc_pkg::STORE_AW'(wr_slot);
	assign fnum_in   = op_q.frame_address[sbc_pkg::ADDR_W-1:FB];
	// a slab never written still holds its own frame numbers
	assign fnum_out  = written_q[take_slab_q] ? rd_data_q : sbc_pkg::FNUM_W'(take_addr);

	always_comb begin
		stk_we      = 1'b0;
		stk_idx     = stk_cnt_q[sbc_pkg::STK_IDX_W-1:0];
		stk_wdata   = take_slab_q;
		stk_cnt_n   = stk_cnt_q;
		take_slab_n = take_slab_q;
		take_cnt_n  = take_cnt_q;
		give_slab_n = give_slab_q;
		give_cnt_n  = give_cnt_q;
		mem_we      = 1'b0;
		wr_slab     = give_slab_q;
		wr_slot     = sbc_pkg::SLOT_W'(give_cnt_q);
		rsp_n.granted_count = '0;
		rsp_n.out_address   = '0;
		rsp_n.status        = sbc_pkg::STAT_OK;
		case (op_q.mode)
			sbc_pkg::MODE_CHECK: begin
				if (take_cnt_q != '0) begin
					if ((sbc_pkg::REQ_W + sbc_pkg::CNT_W)'(take_cnt_q) <
						(sbc_pkg::REQ_W + sbc_pkg::CNT_W)'(op_q.request_count))
						rsp_n.granted_count = sbc_pkg::GRANT_W'(take_cnt_q);
					else
						rsp_n.granted_count = sbc_pkg::GRANT_W'(op_q.request_count);
				end else if (stk_cnt_q != '0) begin
					// swap the top full slab in, park the empty one in its place
					stk_idx     = sbc_pkg::STK_IDX_W'(stk_cnt_q - sbc_pkg::STK_W'(1));
					stk_we      = 1'b1;
					stk_wdata   = take_slab_q;
					stk_cnt_n   = stk_cnt_q - sbc_pkg::STK_W'(1);
					take_slab_n = stack_q[stk_idx];
					take_cnt_n  = sbc_pkg::CNT_W'(FPS);
					if ((sbc_pkg::REQ_W + sbc_pkg::CNT_W)'(op_q.request_count) <
						(sbc_pkg::REQ_W + sbc_pkg::CNT_W)'(FPS))
						rsp_n.granted_count = sbc_pkg::GRANT_W'(op_q.request_count);
					else
						rsp_n.granted_count = sbc_pkg::GRANT_W'(FPS);
				end
			end
			sbc_pkg::MODE_CONSUME: begin
				if (take_cnt_q == '0) begin
					rsp_n.status = sbc_pkg::STAT_EMPTY;
				end else begin
					take_cnt_n        = take_cnt_q - sbc_pkg::CNT_W'(1);
					rsp_n.out_address = sbc_pkg::ADDR_W'({fnum_out, {FB{1'b0}}});
				end
			end
			sbc_pkg::MODE_PRODUCE: begin
				if (give_cnt_q < sbc_pkg::CNT_W'(FPS)) begin
					mem_we     = 1'b1;
					give_cnt_n = give_cnt_q + sbc_pkg::CNT_W'(1);
				end else if (stk_cnt_q >= sbc_pkg::STK_W'(NS)) begin
					rsp_n.status = sbc_pkg::STAT_OVERFLOW;
				end else begin
					// push the full give slab, take the empty one found there
					stk_we      = 1'b1;
					stk_wdata   = give_slab_q;
					stk_cnt_n   = stk_cnt_q + sbc_pkg::STK_W'(1);
					give_slab_n = stack_q[stk_idx];
					give_cnt_n  = sbc_pkg::CNT_W'(1);
					mem_we      = 1'b1;
					wr_slab     = stack_q[stk_idx];
					wr_slot     = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) stack_q[i] <= sbc_pkg::SLAB_W'(i);
			stk_cnt_q   <= sbc_pkg::STK_W'(NS);
			take_slab_q <= sbc_pkg::SLAB_W'(NS);
			take_cnt_q  <= '0;
			give_slab_q <= sbc_pkg::SLAB_W'(NS + 1);
			give_cnt_q  <= '0;
			written_q   <= '0;
		end else if (cmd.exec) begin
			if (stk_we) stack_q[stk_idx] <= stk_wdata;
			stk_cnt_q   <= stk_cnt_n;
			take_slab_q <= take_slab_n;
			take_cnt_q  <= take_cnt_n;
			give_slab_q <= give_slab_n;
			give_cnt_q  <= give_cnt_n;
			if (mem_we) written_q[wr_slab] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) store_mem[wr_addr] <= fnum_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) rd_data_q <= store_mem[take_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) op_q <= req_data;
		if (cmd.exec) rsp_q <= rsp_n;
	end

	assign rsp_data = rsp_q;

endmodule

FILE: rtl/slab_buffer_cache_allocator_core.sv
// ----------------------------------------------------------------------------
// slab_buffer_cache_allocator_core: slab-based free frame allocator
// Hands out and takes back packet frame addresses from a pool of slabs.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  carries one request: mode (check, consume, produce), request_count
//        for check and frame_address for produce.
//   rsp  carries exactly one response per request: granted_count,
//        out_address and status (ok, empty take slab, stack overflow).
//   A transaction on either channel completes when valid and ready are high.
// Timing:
//   The accepting edge also registers the frame store read of the current
//   take slot; the request runs at a later edge, once the response
//   register is free, and that edge loads the response register. A new
//   request is accepted only after the last one has run, set by this
//   accept-then-execute sequence around the registered read port.
//   rsp.valid is registered and rises at the edge that runs the request.
// Reset:
//   All pool slabs sit full on the stack; no clearing pass is needed since
//   per-slab written flags supply the initial frame numbers.
// Backpressure:
//   The response register holds while rsp.ready is low. The next request is
//   still accepted; it then waits until the held response is taken.
// ----------------------------------------------------------------------------
module slab_buffer_cache_allocator_core (
	input  logic      clk,
	input  logic      arst_n,
	sbc_req_if.sink   cmd,
	sbc_rsp_if.source rsp
);

	sbc_pkg::dp_cmd_t dp_cmd;

	// sequence each transaction: accept, then execute into the response register
	sbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (dp_cmd)
	);

	// slab bookkeeping, frame store and response payload
	sbc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.req_data (cmd.data),
		.rsp_data (rsp.data)
	);

endmodule

FILE: test/tb_slab_buffer_cache_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_slab_buffer_cache_allocator_core: self-checking bench of the slab allocator
// Drives check, consume and produce operations through the request channel,
// predicts every response from a private model of the slab pool and compares
// it field by field against the response channel under random backpressure.
// ----------------------------------------------------------------------------
module tb_slab_buffer_cache_allocator_core;
	import sbc_pkg::*;

	// mode code the block leaves unused; it must answer all zeros
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int QUIET_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 8;
	localparam int DRAIN_BUDGET = 110;

	// idle percentages per traffic phase, sender and receiver swapped in phase 1
	localparam int SEND_IDLE_PCT [3] = '{7, 55, 0};
	localparam int RECV_IDLE_PCT [3] = '{55, 7, 0};

	typedef struct {
		req_item_t item;
		int        phase;
	} frame_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sbc_req_if cmd_ch();
	sbc_rsp_if rsp_ch();

	slab_buffer_cache_allocator_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Stimulus store and response expectations
	// ------------------------------------------------------------------
	frame_op_t frame_ops [$];
	rsp_item_t pending_replies [$];

	int err_cnt      = 0;
	int quiet_cycles = 0;
	int drive_phase  = 0;
	int rx_phase     = 0;

	// ------------------------------------------------------------------
	// Private copy of the slab pool used to predict responses
	// ------------------------------------------------------------------
	logic [SLAB_W-1:0] slab_stk  [NUM_SLABS];
	logic [FNUM_W-1:0] frame_mem [STORE_SIZE];
	int unsigned       stk_depth;
	int unsigned       take_id;
	int unsigned       take_fill;
	int unsigned       give_id;
	int unsigned       give_fill;

	// Rough fill counts tracked while the stimulus is built, so that the
	// generator can steer toward refills, overflow and a running-dry take slab.
	int unsigned gen_take_fill   = 0;
	int unsigned gen_stack_depth = NUM_SLABS;
	int unsigned gen_give_fill   = 0;

	function automatic bit idle_roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Apply one request to the private pool and return the response it must give.
	function automatic rsp_item_t predict_alloc(req_item_t op);
		rsp_item_t   res;
		int unsigned want;
		int unsigned swap_id;
		res  = '0;
		want = op.request_count;
		case (op.mode)
			MODE_CHECK: begin
				if (take_fill != 0) begin
					res.granted_count = GRANT_W'((take_fill < want) ? take_fill : want);
				end else if (stk_depth != 0) begin
					// refill: swap the empty take slab for the top full slab
					stk_depth--;
					swap_id            = slab_stk[stk_depth];
					slab_stk[stk_depth] = SLAB_W'(take_id);
					take_id            = swap_id;
					take_fill          = FRAMES_PER_SLAB;
					res.granted_count  = GRANT_W'((want < FRAMES_PER_SLAB) ? want : FRAMES_PER_SLAB);
				end
			end
			MODE_CONSUME: begin
				if (take_fill == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					take_fill--;
					res.out_address = {frame_mem[take_id * FRAMES_PER_SLAB + take_fill],
						{FRAME_BYTES_LOG2{1'b0}}};
				end
			end
			MODE_PRODUCE: begin
				if (give_fill < FRAMES_PER_SLAB) begin
					frame_mem[give_id * FRAMES_PER_SLAB + give_fill] =
						op.frame_address[ADDR_W-1:FRAME_BYTES_LOG2];
					give_fill++;
				end else if (stk_depth >= NUM_SLABS) begin
					// no room on the stack: drop the frame
					res.status = STAT_OVERFLOW;
				end else begin
					swap_id             = slab_stk[stk_depth];
					slab_stk[stk_depth] = SLAB_W'(give_id);
					stk_depth++;
					give_id   = swap_id;
					frame_mem[give_id * FRAMES_PER_SLAB] =
						op.frame_address[ADDR_W-1:FRAME_BYTES_LOG2];
					give_fill = 1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Queue one request and advance the generator's fill counts.
	function automatic void queue_req(logic [MODE_W-1:0] op, logic [REQ_W-1:0] want,
		logic [ADDR_W-1:0] addr, int ph);
		frame_op_t fo;
		fo.item.mode          = op;
		fo.item.request_count = want;
		fo.item.frame_address = addr;
		fo.phase              = ph;
		frame_ops.push_back(fo);
		case (op)
			MODE_CHECK: begin
				if (gen_take_fill == 0 && gen_stack_depth != 0) begin
					gen_stack_depth--;
					gen_take_fill = FRAMES_PER_SLAB;
				end
			end
			MODE_CONSUME: begin
				if (gen_take_fill != 0)
					gen_take_fill--;
			end
			MODE_PRODUCE: begin
				if (gen_give_fill < FRAMES_PER_SLAB) begin
					gen_give_fill++;
				end else if (gen_stack_depth < NUM_SLABS) begin
					gen_stack_depth++;
					gen_give_fill = 1;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] rand_want();
		// favor small requests so partial grants show up often
		if ($urandom_range(3) == 0)
			return REQ_W'($urandom_range(8));
		return REQ_W'($urandom());
	endfunction

	// One request of random operation and random content, noise included.
	function automatic void queue_mixed(int ph);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 30)
			queue_req(MODE_CONSUME, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
		else if (pick < 60)
			queue_req(MODE_PRODUCE, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
		else if (pick < 90)
			queue_req(MODE_CHECK, rand_want(), ADDR_W'($urandom()), ph);
		else
			queue_req(MODE_UNUSED, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
	endfunction

	// Mostly produce until the give slab and the stack are full, then hit the
	// overflow a few times.
	function automatic void fill_episode(int ph, int hits);
		int drops;
		drops = 0;
		while (drops < hits) begin
			if (gen_give_fill == FRAMES_PER_SLAB && gen_stack_depth == NUM_SLABS) begin
				queue_req(MODE_PRODUCE, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
				drops++;
			end else if ($urandom_range(99) < 85) begin
				queue_req(MODE_PRODUCE, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
			end else begin
				queue_mixed(ph);
			end
		end
	endfunction

	// Consume steadily for a bounded stretch: refill with check whenever the
	// take slab runs dry, then probe with consume and check.
	function automatic void drain_episode(int ph, int budget);
		int unsigned pick;
		int          sent;
		sent = 0;
		while ((gen_take_fill != 0 || gen_stack_depth != 0) && sent < budget) begin
			pick = $urandom_range(99);
			if (gen_take_fill == 0 || pick < 6)
				queue_req(MODE_CHECK, rand_want(), ADDR_W'($urandom()), ph);
			else if (pick < 8)
				queue_req(MODE_UNUSED, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
			else
				queue_req(MODE_CONSUME, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
			sent++;
		end
		repeat (2) begin
			queue_req(MODE_CONSUME, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
			queue_req(MODE_CHECK, REQ_W'($urandom()), ADDR_W'($urandom()), ph);
		end
		queue_req(MODE_CHECK, '0, '0, ph);
	endfunction

	// ------------------------------------------------------------------
	// Driver: present the next pending request, or idle at random.
	// Advance only when the current transaction completes or nothing is held.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data  <= '0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (frame_ops.size() != 0 && !idle_roll(SEND_IDLE_PCT[frame_ops[0].phase])) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data  <= frame_ops[0].item;
				drive_phase  <= frame_ops[0].phase;
				void'(frame_ops.pop_front());
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check completed response transactions, predict each accepted
	// request, drive rsp.ready at random and watch for a stalled block.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			quiet_cycles = 0;
		end else begin
			rsp_ch.ready <= !idle_roll(RECV_IDLE_PCT[rx_phase]);

			// check the response first: it always belongs to an earlier request
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_replies.size() == 0) begin
					$error("unexpected response: granted_count %0d out_address 0x%0h status %0d",
						rsp_ch.data.granted_count, rsp_ch.data.out_address, rsp_ch.data.status);
					err_cnt++;
				end else begin
					if (rsp_ch.data.granted_count !== pending_replies[0].granted_count) begin
						$error("granted_count: expected %0d, got %0d",
							pending_replies[0].granted_count, rsp_ch.data.granted_count);
						err_cnt++;
					end
					if (rsp_ch.data.out_address !== pending_replies[0].out_address) begin
						$error("out_address: expected 0x%0h, got 0x%0h",
							pending_replies[0].out_address, rsp_ch.data.out_address);
						err_cnt++;
					end
					if (rsp_ch.data.status !== pending_replies[0].status) begin
						$error("status: expected %0d, got %0d",
							pending_replies[0].status, rsp_ch.data.status);
						err_cnt++;
					end
					void'(pending_replies.pop_front());
				end
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				pending_replies.push_back(predict_alloc(cmd_ch.data));
				rx_phase = drive_phase;
			end

			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("tb_slab_buffer_cache_allocator_core failed");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset the pool model, build the stimulus, release reset,
	// then wait for every response and report.
	// ------------------------------------------------------------------
	initial begin
		// pool slabs full on the stack, spare slabs empty
		for (int i = 0; i < NUM_SLABS; i++)
			slab_stk[i] = SLAB_W'(i);
		for (int i = 0; i < STORE_SIZE; i++)
			frame_mem[i] = (i < NUM_SLABS * FRAMES_PER_SLAB) ? FNUM_W'(i) : '0;
		stk_depth = NUM_SLABS;
		take_id   = NUM_SLABS;
		take_fill = 0;
		give_id   = NUM_SLABS + 1;
		give_fill = 0;

		// directed: consume before any refill, refill on a zero request,
		// clamped and partial grants, both unused-mode extremes, address
		// alignment at the field edges
		queue_req(MODE_CONSUME, '1, '1, 0);
		queue_req(MODE_CHECK, '0, '1, 0);
		queue_req(MODE_CHECK, '1, '0, 0);
		queue_req(MODE_CHECK, REQ_W'(FRAMES_PER_SLAB), '0, 0);
		queue_req(MODE_CHECK, REQ_W'(FRAMES_PER_SLAB - 1), '0, 0);
		queue_req(MODE_CONSUME, '0, '0, 0);
		queue_req(MODE_CONSUME, '1, '1, 0);
		queue_req(MODE_CHECK, '1, '0, 0);
		queue_req(MODE_UNUSED, '1, '1, 0);
		queue_req(MODE_UNUSED, '0, '0, 0);
		queue_req(MODE_PRODUCE, '0, '1, 0);
		queue_req(MODE_PRODUCE, '1, ADDR_W'((1 << FRAME_BYTES_LOG2) - 1), 0);
		queue_req(MODE_PRODUCE, '0, ADDR_W'(1 << FRAME_BYTES_LOG2), 0);
		queue_req(MODE_PRODUCE, '0, '0, 0);
		queue_req(MODE_CONSUME, '0, '0, 0);
		queue_req(MODE_CHECK, REQ_W'(1), '0, 0);

		// phase 0: busy sender, slow receiver; drive the give side to overflow
		fill_episode(0, 3);
		repeat (150) queue_mixed(0);

		// phase 1: slow sender, busy receiver; a consume-heavy stretch with refills
		drain_episode(1, DRAIN_BUDGET);
		repeat (100) queue_mixed(1);

		// phase 2: no idling; produce bursts, consume-heavy bursts and mixed stretches
		repeat (12) begin
			case ($urandom_range(2))
				0: repeat ($urandom_range(10, 60))
					queue_req(MODE_PRODUCE, REQ_W'($urandom()), ADDR_W'($urandom()), 2);
				1: repeat ($urandom_range(10, 40)) begin
					if ($urandom_range(7) == 0)
						queue_req(MODE_CHECK, rand_want(), ADDR_W'($urandom()), 2);
					else
						queue_req(MODE_CONSUME, REQ_W'($urandom()), ADDR_W'($urandom()), 2);
				end
				default: repeat ($urandom_range(10, 30)) queue_mixed(2);
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// hold until every request is taken, then every response is back
		while (frame_ops.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("tb_slab_buffer_cache_allocator_core passed");
		else
			$display("tb_slab_buffer_cache_allocator_core failed");
		$finish;
	end

endmodule
